@@ sv/tc_pkg.sv @@
// shared widths, constants and pipeline stage type of the circumcenter block
package tc_pkg;
   localparam int COORD_BITS = 16;
   localparam int FRAC_BITS  = 16;
   localparam int FIELD_W    = 16;
   localparam int OUT_W      = 48;
   localparam int LIMIT_W    = 34;
   localparam int CSR_DATA_W = 64;
   localparam int CSR_ADDR_W = 4;
   localparam logic [CSR_ADDR_W-1:0] ADDR_LIMIT = 4'h0;
   localparam logic [LIMIT_W-1:0] LIMIT_RESET = 34'd1;

   localparam int AB_W   = COORD_BITS + 1;
   localparam int PR_W   = 2 * AB_W;
   localparam int SQ_W   = 2 * AB_W;
   localparam int DM_W   = 2 * AB_W + 1;
   localparam int D_W    = DM_W + 1;
   localparam int N_W    = SQ_W + AB_W + 1;
   localparam int NM_W   = N_W - 1;
   localparam int NUM_W  = NM_W + FRAC_BITS;
   localparam int LC_W   = DM_W > LIMIT_W ? DM_W : LIMIT_W;
   localparam int CMP_W  = NUM_W > 64 ? NUM_W : 64;
   localparam int SUM_W  = 66;

   localparam logic [63:0] QCAP = 64'h4000_0000_0000_0000;
   localparam logic signed [OUT_W-1:0] OUT_MAX = {1'b0, {(OUT_W-1){1'b1}}};
   localparam logic signed [OUT_W-1:0] OUT_MIN = {1'b1, {(OUT_W-1){1'b0}}};

   typedef struct packed {
      logic                         valid;
      logic                         degenerate;
      logic                         neg_x;
      logic                         neg_y;
      logic signed [COORD_BITS-1:0] ax;
      logic signed [COORD_BITS-1:0] ay;
      logic [DM_W-1:0]              dm;
      logic [DM_W-1:0]              rem_x;
      logic [DM_W-1:0]              rem_y;
      logic [NUM_W-1:0]             w_x;
      logic [NUM_W-1:0]             w_y;
   } stage_type;
endpackage

@@ sv/tc_req_if.sv @@
// request channel carrying the three triangle vertices
interface tc_req_if;
   import tc_pkg::*;
   logic                      valid;
   logic                      ready;
   logic signed [FIELD_W-1:0] ax;
   logic signed [FIELD_W-1:0] ay;
   logic signed [FIELD_W-1:0] bx;
   logic signed [FIELD_W-1:0] by;
   logic signed [FIELD_W-1:0] cx;
   logic signed [FIELD_W-1:0] cy;
   modport source (output valid, ax, ay, bx, by, cx, cy, input ready);
   modport sink (input valid, ax, ay, bx, by, cx, cy, output ready);
endinterface

@@ sv/tc_rsp_if.sv @@
// result channel carrying the circumcenter and its flags
interface tc_rsp_if;
   import tc_pkg::*;
   logic                    valid;
   logic                    ready;
   logic signed [OUT_W-1:0] center_x;
   logic signed [OUT_W-1:0] center_y;
   logic                    degenerate;
   logic                    saturated;
   modport source (output valid, center_x, center_y, degenerate, saturated, input ready);
   modport sink (input valid, center_x, center_y, degenerate, saturated, output ready);
endinterface

@@ sv/tc_front.sv @@
// edge vectors, cross product, squared lengths and numerators
module tc_front
   import tc_pkg::*;
(
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      en,
   input  logic                      in_valid,
   input  logic signed [FIELD_W-1:0] ax,
   input  logic signed [FIELD_W-1:0] ay,
   input  logic signed [FIELD_W-1:0] bx,
   input  logic signed [FIELD_W-1:0] by,
   input  logic signed [FIELD_W-1:0] cx,
   input  logic signed [FIELD_W-1:0] cy,
   input  logic [LIMIT_W-1:0]        limit,
   output stage_type                 out
);
   logic [4:0] v_ff;

   // stage 1
   logic signed [COORD_BITS-1:0] ax1_ff, ay1_ff;
   logic signed [AB_W-1:0] abx1_ff, aby1_ff, acx1_ff, acy1_ff;
   // stage 2
   logic signed [COORD_BITS-1:0] ax2_ff, ay2_ff;
   logic signed [AB_W-1:0] abx2_ff, aby2_ff, acx2_ff, acy2_ff;
   logic signed [PR_W-1:0] pd1_ff, pd2_ff, sq1_ff, sq2_ff, sq3_ff, sq4_ff;
   // stage 3
   logic signed [COORD_BITS-1:0] ax3_ff, ay3_ff;
   logic signed [AB_W-1:0] abx3_ff, aby3_ff, acx3_ff, acy3_ff;
   logic signed [D_W-1:0] d3_ff;
   logic [SQ_W-1:0] ab2_ff, ac2_ff;
   // stage 4
   logic signed [COORD_BITS-1:0] ax4_ff, ay4_ff;
   logic signed [N_W-1:0] m1_ff, m2_ff, m3_ff, m4_ff;
   logic [DM_W-1:0] dm4_ff;
   logic dneg4_ff, deg4_ff;
   // stage 5
   logic signed [COORD_BITS-1:0] ax5_ff, ay5_ff;
   logic signed [N_W-1:0] nx_ff, ny_ff;
   logic [DM_W-1:0] dm5_ff;
   logic dneg5_ff, deg5_ff;
   stage_type out_ff;

   logic signed [COORD_BITS-1:0] sax, say, sbx, sby, scx, scy;
   logic signed [D_W-1:0] d_in;
   logic [DM_W-1:0] dm_in;
   logic deg_in;
   logic [NM_W-1:0] magx_in, magy_in;

   always_comb begin
      sax = ax[COORD_BITS-1:0];
      say = ay[COORD_BITS-1:0];
      sbx = bx[COORD_BITS-1:0];
      sby = by[COORD_BITS-1:0];
      scx = cx[COORD_BITS-1:0];
      scy = cy[COORD_BITS-1:0];
      d_in = (D_W'(pd1_ff) - D_W'(pd2_ff)) <<< 1;
      dm_in = d3_ff[D_W-1] ? DM_W'(-d3_ff) : DM_W'(d3_ff);
      deg_in = (d3_ff == '0) || (LC_W'(dm_in) < LC_W'(limit));
      magx_in = nx_ff[N_W-1] ? NM_W'(-nx_ff) : NM_W'(nx_ff);
      magy_in = ny_ff[N_W-1] ? NM_W'(-ny_ff) : NM_W'(ny_ff);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v_ff <= '0;
         out_ff.valid <= 1'b0;
      end else if (en) begin
         v_ff <= {v_ff[3:0], in_valid};
         ax1_ff <= sax;
         ay1_ff <= say;
         abx1_ff <= AB_W'(sbx) - AB_W'(sax);
         aby1_ff <= AB_W'(sby) - AB_W'(say);
         acx1_ff <= AB_W'(scx) - AB_W'(sax);
         acy1_ff <= AB_W'(scy) - AB_W'(say);

         ax2_ff <= ax1_ff;
         ay2_ff <= ay1_ff;
         abx2_ff <= abx1_ff;
         aby2_ff <= aby1_ff;
         acx2_ff <= acx1_ff;
         acy2_ff <= acy1_ff;
         pd1_ff <= PR_W'(abx1_ff) * PR_W'(acy1_ff);
         pd2_ff <= PR_W'(aby1_ff) * PR_W'(acx1_ff);
         sq1_ff <= PR_W'(abx1_ff) * PR_W'(abx1_ff);
         sq2_ff <= PR_W'(aby1_ff) * PR_W'(aby1_ff);
         sq3_ff <= PR_W'(acx1_ff) * PR_W'(acx1_ff);
         sq4_ff <= PR_W'(acy1_ff) * PR_W'(acy1_ff);

         ax3_ff <= ax2_ff;
         ay3_ff <= ay2_ff;
         abx3_ff <= abx2_ff;
         aby3_ff <= aby2_ff;
         acx3_ff <= acx2_ff;
         acy3_ff <= acy2_ff;
         d3_ff <= d_in;
         ab2_ff <= SQ_W'($unsigned(sq1_ff)) + SQ_W'($unsigned(sq2_ff));
         ac2_ff <= SQ_W'($unsigned(sq3_ff)) + SQ_W'($unsigned(sq4_ff));

         ax4_ff <= ax3_ff;
         ay4_ff <= ay3_ff;
         m1_ff <= N_W'($signed({1'b0, ab2_ff}) * acy3_ff);
         m2_ff <= N_W'($signed({1'b0, ac2_ff}) * aby3_ff);
         m3_ff <= N_W'($signed({1'b0, ac2_ff}) * abx3_ff);
         m4_ff <= N_W'($signed({1'b0, ab2_ff}) * acx3_ff);
         dm4_ff <= dm_in;
         dneg4_ff <= d3_ff[D_W-1];
         deg4_ff <= deg_in;

         ax5_ff <= ax4_ff;
         ay5_ff <= ay4_ff;
         nx_ff <= m1_ff - m2_ff;
         ny_ff <= m3_ff - m4_ff;
         dm5_ff <= dm4_ff;
         dneg5_ff <= dneg4_ff;
         deg5_ff <= deg4_ff;

         out_ff.valid <= v_ff[4];
         out_ff.degenerate <= deg5_ff;
         out_ff.neg_x <= nx_ff[N_W-1] ^ dneg5_ff;
         out_ff.neg_y <= ny_ff[N_W-1] ^ dneg5_ff;
         out_ff.ax <= ax5_ff;
         out_ff.ay <= ay5_ff;
         out_ff.dm <= dm5_ff;
         out_ff.rem_x <= '0;
         out_ff.rem_y <= '0;
         out_ff.w_x <= NUM_W'(magx_in) << FRAC_BITS;
         out_ff.w_y <= NUM_W'(magy_in) << FRAC_BITS;
      end
   end

   assign out = out_ff;
endmodule

@@ sv/tc_div_stage.sv @@
// one restoring division step for both coordinates
module tc_div_stage
   import tc_pkg::*;
(
   input  logic      clock,
   input  logic      reset,
   input  logic      en,
   input  stage_type s_in,
   output stage_type s_out
);
   stage_type s_ff;
   stage_type s_nx_in;
   logic [DM_W:0] shx, shy;
   logic gex, gey;

   always_comb begin
      s_nx_in = s_in;
      shx = {s_in.rem_x, s_in.w_x[NUM_W-1]};
      shy = {s_in.rem_y, s_in.w_y[NUM_W-1]};
      gex = shx >= {1'b0, s_in.dm};
      gey = shy >= {1'b0, s_in.dm};
      s_nx_in.rem_x = gex ? DM_W'(shx - {1'b0, s_in.dm}) : DM_W'(shx);
      s_nx_in.rem_y = gey ? DM_W'(shy - {1'b0, s_in.dm}) : DM_W'(shy);
      s_nx_in.w_x = {s_in.w_x[NUM_W-2:0], gex};
      s_nx_in.w_y = {s_in.w_y[NUM_W-2:0], gey};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s_ff.valid <= 1'b0;
      end else if (en) begin
         s_ff <= s_nx_in;
      end
   end

   assign s_out = s_ff;
endmodule

@@ sv/tc_back.sv @@
// quotient capping, sign, offset by vertex a, clamping, degenerate override and result register
module tc_back
   import tc_pkg::*;
(
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     en,
   input  stage_type                s_in,
   output logic                     out_valid,
   output logic signed [OUT_W-1:0]  center_x,
   output logic signed [OUT_W-1:0]  center_y,
   output logic                     degenerate,
   output logic                     saturated
);
   logic b_valid_ff, b_deg_ff;
   logic signed [COORD_BITS-1:0] b_ax_ff, b_ay_ff;
   logic signed [63:0] b_qx_ff, b_qy_ff;

   logic o_valid_ff, o_deg_ff, o_sat_ff;
   logic signed [OUT_W-1:0] o_x_ff, o_y_ff;

   logic [63:0] qmx, qmy;
   logic signed [SUM_W-1:0] sx, sy;
   logic signed [OUT_W-1:0] x_in, y_in;
   logic satx, saty;

   always_comb begin
      qmx = (CMP_W'(s_in.w_x) > CMP_W'(QCAP)) ? QCAP : 64'(s_in.w_x);
      qmy = (CMP_W'(s_in.w_y) > CMP_W'(QCAP)) ? QCAP : 64'(s_in.w_y);
      sx = (SUM_W'(b_ax_ff) <<< FRAC_BITS) + SUM_W'(b_qx_ff);
      sy = (SUM_W'(b_ay_ff) <<< FRAC_BITS) + SUM_W'(b_qy_ff);
      satx = 1'b1;
      saty = 1'b1;
      if (sx > SUM_W'(OUT_MAX)) begin
         x_in = OUT_MAX;
      end else if (sx < SUM_W'(OUT_MIN)) begin
         x_in = OUT_MIN;
      end else begin
         x_in = OUT_W'(sx);
         satx = 1'b0;
      end
      if (sy > SUM_W'(OUT_MAX)) begin
         y_in = OUT_MAX;
      end else if (sy < SUM_W'(OUT_MIN)) begin
         y_in = OUT_MIN;
      end else begin
         y_in = OUT_W'(sy);
         saty = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         b_valid_ff <= 1'b0;
         o_valid_ff <= 1'b0;
      end else if (en) begin
         b_valid_ff <= s_in.valid;
         b_deg_ff <= s_in.degenerate;
         b_ax_ff <= s_in.ax;
         b_ay_ff <= s_in.ay;
         b_qx_ff <= s_in.neg_x ? -$signed(qmx) : $signed(qmx);
         b_qy_ff <= s_in.neg_y ? -$signed(qmy) : $signed(qmy);

         o_valid_ff <= b_valid_ff;
         o_deg_ff <= b_deg_ff;
         o_sat_ff <= ~b_deg_ff & (satx | saty);
         o_x_ff <= b_deg_ff ? OUT_MAX : x_in;
         o_y_ff <= b_deg_ff ? OUT_MAX : y_in;
      end
   end

   assign out_valid = o_valid_ff;
   assign center_x = o_x_ff;
   assign center_y = o_y_ff;
   assign degenerate = o_deg_ff;
   assign saturated = o_sat_ff;
endmodule

@@ sv/triangle_circumcenter.sv @@
// Circumcenter of a triangle given as three signed integer vertices, returned in signed
// Q31.16 with truncation toward zero and saturation. One triangle is taken every cycle
// while the result is not stalled; each request passes through the edge products and
// numerators, the pipelined restoring divider (one quotient bit a stage), and then the
// capping and clamping. A stalled result freezes the whole pipeline, so the
// request side is ready exactly when the result register is empty or being taken.
// Triangles whose doubled cross product is zero or below degenerate_limit (address 0x0,
// 64-bit write, reset 1) return the largest positive value in both coordinates.
module triangle_circumcenter
   import tc_pkg::*;
(
   input  logic                  clock,
   input  logic                  reset,
   tc_req_if.sink                req_port,
   tc_rsp_if.source              rsp_port,
   input  logic                  csr_psel,
   input  logic                  csr_penable,
   input  logic                  csr_pwrite,
   input  logic [CSR_ADDR_W-1:0] csr_paddr,
   input  logic [CSR_DATA_W-1:0] csr_pwdata,
   output logic [CSR_DATA_W-1:0] csr_prdata,
   output logic                  csr_pready
);
   logic [LIMIT_W-1:0] limit_ff;
   logic en;
   logic out_valid;
   stage_type stage_q [0:NUM_W];

   always_ff @(posedge clock) begin
      if (reset) begin
         limit_ff <= LIMIT_RESET;
      end else if (csr_psel && csr_penable && csr_pwrite && csr_paddr == ADDR_LIMIT) begin
         limit_ff <= csr_pwdata[LIMIT_W-1:0];
      end
   end

   assign csr_pready = 1'b1;
   assign csr_prdata = (csr_paddr == ADDR_LIMIT) ? CSR_DATA_W'(limit_ff) : '0;

   assign en = ~out_valid | rsp_port.ready;
   assign req_port.ready = en;

   tc_front u_front (
      .clock    (clock),
      .reset    (reset),
      .en       (en),
      .in_valid (req_port.valid),
      .ax       (req_port.ax),
      .ay       (req_port.ay),
      .bx       (req_port.bx),
      .by       (req_port.by),
      .cx       (req_port.cx),
      .cy       (req_port.cy),
      .limit    (limit_ff),
      .out      (stage_q[0])
   );

   for (genvar i = 0; i < NUM_W; i++) begin : g_div
      tc_div_stage u_stage (
         .clock (clock),
         .reset (reset),
         .en    (en),
         .s_in  (stage_q[i]),
         .s_out (stage_q[i+1])
      );
   end

   tc_back u_back (
      .clock      (clock),
      .reset      (reset),
      .en         (en),
      .s_in       (stage_q[NUM_W]),
      .out_valid  (out_valid),
      .center_x   (rsp_port.center_x),
      .center_y   (rsp_port.center_y),
      .degenerate (rsp_port.degenerate),
      .saturated  (rsp_port.saturated)
   );

   assign rsp_port.valid = out_valid;

`ifndef NO_ASSERTIONS
   a_deg_inf: assert property (@(posedge clock) disable iff (reset)
      out_valid && rsp_port.degenerate |->
         rsp_port.center_x == OUT_MAX && rsp_port.center_y == OUT_MAX &&
         !rsp_port.saturated)
      else $error("degenerate result not infinity");
   a_stall_hold: assert property (@(posedge clock) disable iff (reset)
      !en |=> $stable(stage_q[NUM_W]) && $stable(stage_q[0]))
      else $error("pipeline moved during stall");
   a_sat_range: assert property (@(posedge clock) disable iff (reset)
      out_valid && rsp_port.saturated |->
         rsp_port.center_x == OUT_MAX || rsp_port.center_x == OUT_MIN ||
         rsp_port.center_y == OUT_MAX || rsp_port.center_y == OUT_MIN)
      else $error("saturated flag without clipped coordinate");
`endif
endmodule
